/* hdl/fhrb_pkg.sv */
`timescale 1ns / 1ps

package fhrb_pkg;

    localparam int HEAT_W = 8;
    localparam int CFG_W = 11;
    localparam int SUM_W = HEAT_W + 3;
    localparam int SUM_SHIFT = 3;
    localparam int COOL_STEP = 4;
    localparam int MIN_DIM = 3;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(320);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(240);

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // one column of the line store: final values two rows up and one row up
    typedef struct packed {
        logic [HEAT_W-1:0] two;
        logic [HEAT_W-1:0] one;
    } line_entry_t;

    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* hdl/fhrb_ram.sv */
`timescale 1ns / 1ps

module fhrb_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/fhrb_out_queue.sv */
`timescale 1ns / 1ps

module fhrb_out_queue
    import fhrb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           pop;

    assign pop = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next = count_reg + (PW+1)'(push.cnt) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            slot_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    // room for a full two-result transaction
    assign room = count_reg <= (PW+1)'(QUEUE_DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign head = slot_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("output queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> count_reg <= (PW+1)'(QUEUE_DEPTH - 2))
        else $error("push into queue without room");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push.cnt == 2'd0 |=> count_reg == $past(count_reg) - (PW+1)'(1))
        else $error("pop did not drain queue");

endmodule

/* hdl/fire_heat_raster_blur.sv */
`timescale 1ns / 1ps

// Fire heat blur over a raster stream. One heat pixel enters per clock while
// the output queue has room; the final frame leaves in raster order one pixel
// behind, so the first pixel of a row gives no result and the last pixel of a
// row gives two (the second one carries m_last_of_item). Each row end puts two
// results on the single output port, but the next row's first pixel gives
// none, so a row of W pixels gives W output beats. An input is registered with
// its line-store read, and the adder tree feeds the four-entry output queue.
// Final values of the two rows above live in one MAX_WIDTH-deep line memory of
// 16-bit entries, read once per column into a three-column window and written
// back as the window slides; a row end drains two extra write-backs in the
// following idle write slots. The line store has no reset pass. frame_width
// and frame_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT and may only
// be written while idle.
module fire_heat_raster_blur
    import fhrb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [HEAT_W-1:0]    s_heat_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [HEAT_W-1:0]    m_heat_out,
    output logic                 m_last_of_item,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = ((CFG_W > WDW) ? CFG_W : WDW) + 1;
    localparam int HCMP = ((CFG_W > HDW) ? CFG_W : HDW) + 1;

    // configuration
    logic [CFG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [WCMP-1:0]  w_eff;
    logic [HCMP-1:0]  h_eff;

    // input position
    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;
    logic [WCMP-1:0]  col_plus1;
    logic [HCMP-1:0]  row_plus1;
    logic             accept;
    logic             in_first, in_end, in_interior;

    // read stage
    logic              p1_valid_reg;
    logic [HEAT_W-1:0] p1_heat_reg;
    logic [CW-1:0]     p1_col_reg;
    logic              p1_first_reg, p1_end_reg, p1_inter_reg;
    logic              adv;

    // window and running values
    line_entry_t       win1_reg, win2_reg, rd_entry, ram_q;
    line_entry_t       fwd_data_reg;
    logic              fwd_valid_reg;
    logic [HEAT_W-1:0] held_reg, left_reg;
    logic [SUM_W-1:0]  sum;
    logic [HEAT_W-1:0] scaled, blur_val, pix_val;

    // line store write side
    logic              ram_we, adv_wr;
    logic [CW-1:0]     ram_waddr;
    line_entry_t       ram_wdata;
    logic [1:0]        pend_cnt_reg;
    logic [CW-1:0]     pend0_addr_reg, pend1_addr_reg;
    line_entry_t       pend0_data_reg, pend1_data_reg;

    push_t             push;
    logic              q_room;
    result_t           q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  width_cfg_reg <= cfg_wdata;
                REG_FRAME_HEIGHT: height_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (WCMP'(width_cfg_reg) < WCMP'(MIN_DIM)) begin
            w_eff = WCMP'(MIN_DIM);
        end else if (WCMP'(width_cfg_reg) > WCMP'(MAX_WIDTH)) begin
            w_eff = WCMP'(MAX_WIDTH);
        end else begin
            w_eff = WCMP'(width_cfg_reg);
        end
        if (HCMP'(height_cfg_reg) < HCMP'(MIN_DIM)) begin
            h_eff = HCMP'(MIN_DIM);
        end else if (HCMP'(height_cfg_reg) > HCMP'(MAX_HEIGHT)) begin
            h_eff = HCMP'(MAX_HEIGHT);
        end else begin
            h_eff = HCMP'(height_cfg_reg);
        end
    end

    assign adv = p1_valid_reg && q_room;
    assign s_ready = !p1_valid_reg || q_room;
    assign accept = s_valid && s_ready;

    always_comb begin
        col_plus1 = WCMP'(col_cnt_reg) + WCMP'(1);
        row_plus1 = HCMP'(row_cnt_reg) + HCMP'(1);
        in_first = col_cnt_reg != '0;
        in_end = in_first && (col_plus1 >= w_eff);
        in_interior = (row_cnt_reg >= RW'(2)) && (col_cnt_reg >= CW'(2))
                      && (col_plus1 <= w_eff);
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            if (in_end) begin
                col_cnt_next = '0;
                row_cnt_next = (row_plus1 >= h_eff) ? '0 : RW'(row_plus1);
            end else begin
                col_cnt_next = CW'(col_plus1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            p1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (accept) begin
                p1_valid_reg <= 1'b1;
                // same-cycle write to the column being read goes around the ram
                fwd_valid_reg <= ram_we && (ram_waddr == col_cnt_reg);
            end else if (adv) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_heat_reg <= s_heat_in;
            p1_col_reg <= col_cnt_reg;
            p1_first_reg <= in_first;
            p1_end_reg <= in_end;
            p1_inter_reg <= in_interior;
            fwd_data_reg <= ram_wdata;
        end
    end

    fhrb_ram #(
        .DATA_W ($bits(line_entry_t)),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (ram_q)
    );

    assign rd_entry = fwd_valid_reg ? fwd_data_reg : ram_q;

    always_comb begin
        sum = SUM_W'(win2_reg.two) + SUM_W'(win1_reg.two) + SUM_W'(rd_entry.two)
            + SUM_W'(win2_reg.one) + SUM_W'(rd_entry.one)
            + SUM_W'(left_reg) + SUM_W'(held_reg) + SUM_W'(p1_heat_reg);
        scaled = sum[SUM_W-1:SUM_SHIFT];
        blur_val = (scaled > HEAT_W'(COOL_STEP)) ? scaled - HEAT_W'(COOL_STEP) : '0;
        pix_val = p1_inter_reg ? blur_val : held_reg;
    end

    always_comb begin
        push.cnt = 2'd0;
        push.first.heat = pix_val;
        push.first.last = !p1_end_reg;
        push.second.heat = p1_heat_reg;
        push.second.last = 1'b1;
        if (adv && p1_first_reg) begin
            push.cnt = p1_end_reg ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            left_reg <= '0;
        end else if (adv) begin
            held_reg <= p1_heat_reg;
            if (p1_first_reg) begin
                left_reg <= p1_end_reg ? p1_heat_reg : pix_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            win2_reg <= win1_reg;
            win1_reg <= rd_entry;
        end
    end

    // column two back retires on every output past the first column
    assign adv_wr = adv && p1_first_reg && (p1_col_reg >= CW'(2));

    always_comb begin
        if (pend_cnt_reg != 2'd0) begin
            ram_we = 1'b1;
            ram_waddr = pend0_addr_reg;
            ram_wdata = pend0_data_reg;
        end else begin
            ram_we = adv_wr;
            ram_waddr = p1_col_reg - CW'(2);
            ram_wdata.two = win2_reg.one;
            ram_wdata.one = left_reg;
        end
    end

    // row end queues the last two columns as pending write-backs, which take the write port first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= 2'd0;
        end else if (adv && p1_end_reg) begin
            pend_cnt_reg <= 2'd2;
        end else if (pend_cnt_reg != 2'd0) begin
            pend_cnt_reg <= pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p1_end_reg) begin
            pend0_addr_reg <= p1_col_reg - CW'(1);
            pend0_data_reg.two <= win1_reg.one;
            pend0_data_reg.one <= pix_val;
            pend1_addr_reg <= p1_col_reg;
            pend1_data_reg.two <= rd_entry.one;
            pend1_data_reg.one <= p1_heat_reg;
        end else if (pend_cnt_reg != 2'd0) begin
            pend0_addr_reg <= pend1_addr_reg;
            pend0_data_reg <= pend1_data_reg;
        end
    end

    fhrb_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (q_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (q_head)
    );

    assign m_heat_out = q_head.heat;
    assign m_last_of_item = q_head.last;

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv_wr && pend_cnt_reg != 2'd0))
        else $error("line write collides with pending row-end write");

    a_row_end_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && p1_end_reg |=> pend_cnt_reg == 2'd2)
        else $error("row end did not queue its write-backs");

    a_forward_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ram_we && ram_waddr == col_cnt_reg |=> fwd_valid_reg)
        else $error("read-during-write not forwarded");

    a_end_has_first: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && p1_end_reg |-> p1_first_reg && p1_col_reg >= CW'(2))
        else $error("row end on a column without output");

endmodule
